// ----- hdl/pfe_pkg.sv -----
`timescale 1ns / 1ps

package pfe_pkg;

  typedef logic [24:0] row_t;
  typedef row_t [4:0] square_t;
  typedef logic [4:0] code_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    code_t a;
    code_t b;
  } pair_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } entry_t;

  localparam int NumRows = 5;
  localparam int NumCols = 5;
  localparam int QueueDepth = 8;
  localparam int MaxPush = 4;

  localparam code_t LetterI = 5'd8;
  localparam code_t LetterJ = 5'd9;
  localparam code_t LetterX = 5'd23;
  localparam code_t LetterZ = 5'd25;

  localparam logic [7:0] AsciiUpperA = 8'd65;
  localparam logic [7:0] AsciiUpperZ = 8'd90;
  localparam logic [7:0] AsciiLowerA = 8'd97;
  localparam logic [7:0] AsciiLowerZ = 8'd122;

  localparam logic [2:0] CfgRow0 = 3'd0;
  localparam logic [2:0] CfgRow1 = 3'd1;
  localparam logic [2:0] CfgRow2 = 3'd2;
  localparam logic [2:0] CfgRow3 = 3'd3;
  localparam logic [2:0] CfgRow4 = 3'd4;

  localparam row_t SquareRow0Reset = 25'd4294688;
  localparam row_t SquareRow1Reset = 25'd10755269;
  localparam row_t SquareRow2Reset = 25'd16201099;
  localparam row_t SquareRow3Reset = 25'd21613104;
  localparam row_t SquareRow4Reset = 25'd27025109;

  function automatic pos_t locate(square_t sq, code_t code);
    pos_t p;
    p = '0;
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumCols; c++) begin
        if (sq[r][5*c +: 5] == code) begin
          p.row = 3'(r);
          p.col = 3'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic code_t cell_at(square_t sq, logic [2:0] row, logic [2:0] col);
    row_t  rw;
    code_t cells [NumCols];
    rw = sq[row];
    for (int c = 0; c < NumCols; c++) begin
      cells[c] = rw[5*c +: 5];
    end
    return cells[col];
  endfunction

  function automatic logic [2:0] wrap_inc(logic [2:0] v);
    return (v == 3'(NumRows - 1)) ? 3'd0 : 3'(v + 3'd1);
  endfunction

  function automatic pair_t encrypt_pair(square_t sq, code_t a, code_t b);
    pos_t  pa;
    pos_t  pb;
    pair_t res;
    pa = locate(sq, a);
    pb = locate(sq, b);
    if (pa.col == pb.col) begin
      res.a = cell_at(sq, wrap_inc(pa.row), pa.col);
      res.b = cell_at(sq, wrap_inc(pb.row), pb.col);
    end else if (pa.row == pb.row) begin
      res.a = cell_at(sq, pa.row, wrap_inc(pa.col));
      res.b = cell_at(sq, pb.row, wrap_inc(pb.col));
    end else begin
      res.a = cell_at(sq, pa.row, pb.col);
      res.b = cell_at(sq, pb.row, pa.col);
    end
    return res;
  endfunction

  function automatic logic [6:0] to_ascii(code_t code);
    return 7'(7'd65 + {2'b00, code});
  endfunction

endpackage

// ----- hdl/playfair_encrypt_top.sv -----
`timescale 1ns / 1ps

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+------------------------------
// text in  | text_valid   | text_stall   | text_byte, end_of_message
// cipher   | cipher_valid | cipher_stall | cipher_letter, last_of_run
// config   | cfg_write    | -            | cfg_index, cfg_data
//
// a text beat is registered in the input register, encrypted once the queue has room, and its 0..4 letters
// land in an 8-entry result queue; the first letter shows once it is written there
// the queue drains one letter per cycle while cipher_stall is low
// text_stall rises while the input register holds a beat and the queue lacks
// four free slots; cipher_stall only holds the queue head
// reset loads the standard key square and clears held letter and queue

module playfair_encrypt_top
  import pfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_message,
  output logic        cipher_valid,
  input  logic        cipher_stall,
  output logic [6:0]  cipher_letter,
  output logic        last_of_run
);

  square_t    square;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eom;
  code_t      held_letter;
  logic       held_valid;
  code_t      held_letter_next;
  logic       held_valid_next;

  entry_t     queue [QueueDepth];
  logic [2:0] rd_ptr;
  logic [2:0] wr_ptr;
  logic [3:0] count;

  logic       pop;
  logic [3:0] count_after_pop;
  logic       advance;
  logic       is_letter;
  code_t      code;
  logic       pair_a_en;
  logic       pair_b_en;
  code_t      h1;
  logic       v1;
  pair_t      enc_a;
  pair_t      enc_b;
  entry_t     push_entry [MaxPush];
  logic [2:0] push_count;

  // key square registers
  always_ff @(posedge clk) begin
    if (rst) begin
      square[0] <= SquareRow0Reset;
      square[1] <= SquareRow1Reset;
      square[2] <= SquareRow2Reset;
      square[3] <= SquareRow3Reset;
      square[4] <= SquareRow4Reset;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgRow0: square[0] <= cfg_data;
        CfgRow1: square[1] <= cfg_data;
        CfgRow2: square[2] <= cfg_data;
        CfgRow3: square[3] <= cfg_data;
        CfgRow4: square[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pop             = cipher_valid && !cipher_stall;
  assign count_after_pop = count - {3'b000, pop};
  assign advance         = in_full && (count_after_pop <= 4'(QueueDepth - MaxPush));
  assign text_stall      = in_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_valid && !text_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_byte <= text_byte;
      in_eom  <= end_of_message;
    end
  end

  // letter classification and digraph forming
  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (in_byte >= AsciiUpperA && in_byte <= AsciiUpperZ) begin
      is_letter = 1'b1;
      code      = 5'(in_byte - AsciiUpperA);
    end else if (in_byte >= AsciiLowerA && in_byte <= AsciiLowerZ) begin
      is_letter = 1'b1;
      code      = 5'(in_byte - AsciiLowerA);
    end
    if (code == LetterJ) begin
      code = LetterI;
    end

    pair_a_en = is_letter && held_valid;
    h1        = held_letter;
    v1        = held_valid;
    if (is_letter) begin
      if (!held_valid || code == held_letter) begin
        h1 = code;
        v1 = 1'b1;
      end else begin
        h1 = '0;
        v1 = 1'b0;
      end
    end

    pair_b_en        = in_eom && v1;
    held_letter_next = pair_b_en ? '0 : h1;
    held_valid_next  = pair_b_en ? 1'b0 : v1;
  end

  assign enc_a = encrypt_pair(square, held_letter,
                              (code == held_letter) ? LetterX : code);
  assign enc_b = encrypt_pair(square, h1, LetterZ);

  always_comb begin
    push_entry[0] = '0;
    push_entry[1] = '0;
    push_entry[2] = '0;
    push_entry[3] = '0;
    push_count    = '0;
    if (pair_a_en) begin
      push_entry[0] = '{letter: to_ascii(enc_a.a), last: 1'b0};
      push_entry[1] = '{letter: to_ascii(enc_a.b), last: !pair_b_en};
      if (pair_b_en) begin
        push_entry[2] = '{letter: to_ascii(enc_b.a), last: 1'b0};
        push_entry[3] = '{letter: to_ascii(enc_b.b), last: 1'b1};
        push_count    = 3'd4;
      end else begin
        push_count = 3'd2;
      end
    end else if (pair_b_en) begin
      push_entry[0] = '{letter: to_ascii(enc_b.a), last: 1'b0};
      push_entry[1] = '{letter: to_ascii(enc_b.b), last: 1'b1};
      push_count    = 3'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
    end else if (advance) begin
      held_letter <= held_letter_next;
      held_valid  <= held_valid_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < MaxPush; i++) begin
        if (3'(i) < push_count) begin
          queue[3'(wr_ptr + 3'(i))] <= push_entry[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + 3'd1;
      end
      if (advance) begin
        wr_ptr <= wr_ptr + push_count;
        count  <= count_after_pop + {1'b0, push_count};
      end else begin
        count <= count_after_pop;
      end
    end
  end

  assign cipher_valid  = (count != 4'd0);
  assign cipher_letter = queue[rd_ptr].letter;
  assign last_of_run   = queue[rd_ptr].last;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

import pfe_pkg::*;

class cipher_board;
  row_t   key_rows [5];
  code_t  held_code;
  bit     held_on;
  entry_t due_q [$];
  entry_t batch [4];
  int     batch_n;
  int     errors;
  int     letters_checked;
  int     splits;
  int     flushes;

  function new();
    key_rows[0] = SquareRow0Reset;
    key_rows[1] = SquareRow1Reset;
    key_rows[2] = SquareRow2Reset;
    key_rows[3] = SquareRow3Reset;
    key_rows[4] = SquareRow4Reset;
    held_code = '0;
    held_on = 1'b0;
    batch_n = 0;
    errors = 0;
    letters_checked = 0;
    splits = 0;
    flushes = 0;
  endfunction

  function void set_row(int idx, row_t value);
    key_rows[idx] = value;
  endfunction

  function code_t grid(int r, int c);
    row_t rw;
    rw = key_rows[r % 5];
    return rw[5 * (c % 5) +: 5];
  endfunction

  // last matching cell wins, no match sits at row 0 column 0
  function void find(code_t code, output int r, output int c);
    r = 0;
    c = 0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        if (grid(i, j) == code) begin
          r = i;
          c = j;
        end
      end
    end
  endfunction

  function void add_letter(code_t code);
    entry_t e;
    e.letter = 7'd65 + {2'b00, code};
    e.last = 1'b0;
    batch[batch_n] = e;
    batch_n++;
  endfunction

  function void seal(code_t a, code_t b);
    int ra;
    int ca;
    int rb;
    int cb;
    find(a, ra, ca);
    find(b, rb, cb);
    if (ca == cb) begin
      add_letter(grid(ra + 1, ca));
      add_letter(grid(rb + 1, cb));
    end else if (ra == rb) begin
      add_letter(grid(ra, ca + 1));
      add_letter(grid(rb, cb + 1));
    end else begin
      add_letter(grid(ra, cb));
      add_letter(grid(rb, ca));
    end
  endfunction

  function void note_text(logic [7:0] ch, logic eom);
    code_t  code;
    bit     alpha;
    entry_t e;
    batch_n = 0;
    alpha = 1'b0;
    code = '0;
    if (ch >= AsciiUpperA && ch <= AsciiUpperZ) begin
      alpha = 1'b1;
      code = 5'(ch - AsciiUpperA);
    end else if (ch >= AsciiLowerA && ch <= AsciiLowerZ) begin
      alpha = 1'b1;
      code = 5'(ch - AsciiLowerA);
    end
    if (code == LetterJ) code = LetterI;
    if (alpha) begin
      if (!held_on) begin
        held_code = code;
        held_on = 1'b1;
      end else if (code == held_code) begin
        seal(held_code, LetterX);
        splits++;
      end else begin
        seal(held_code, code);
        held_on = 1'b0;
        held_code = '0;
      end
    end
    if (eom && held_on) begin
      seal(held_code, LetterZ);
      held_on = 1'b0;
      held_code = '0;
      flushes++;
    end
    for (int k = 0; k < batch_n; k++) begin
      e = batch[k];
      e.last = (k == batch_n - 1);
      due_q = {due_q, e};
    end
  endfunction

  function void check_letter(logic [6:0] letter, logic last);
    entry_t want;
    if (due_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected cipher letter %h last %b", $time, letter, last);
    end else begin
      want = due_q.pop_front();
      letters_checked++;
      if (want.letter !== letter || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: cipher mismatch: expected letter %h last %b, got letter %h last %b",
                   $time, want.letter, want.last, letter, last);
      end
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module tb;

  typedef enum {FlowFree, FlowLight, FlowHeavy, FlowBeat} flow_t;

  localparam int WatchLimit = 2000;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 96;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [24:0] cfg_data;
  logic        text_valid;
  logic        text_stall;
  logic [7:0]  text_byte;
  logic        end_of_message;
  logic        cipher_valid;
  logic        cipher_stall;
  logic [6:0]  cipher_letter;
  logic        last_of_run;

  cipher_board board;
  flow_t       stall_mode;
  int          mode_left;
  int          hold_req;
  int          hold_left;
  int          holds_done;
  int          burst_left;
  int          beats_sent;
  int          useful_beats;
  int          squares_loaded;
  int          idle_cycles;

  playfair_encrypt_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text_byte     (text_byte),
    .end_of_message(end_of_message),
    .cipher_valid  (cipher_valid),
    .cipher_stall  (cipher_stall),
    .cipher_letter (cipher_letter),
    .last_of_run   (last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = HoldCycles;
      hold_req = 0;
      holds_done++;
    end
    if (mode_left == 0) begin
      stall_mode = flow_t'($urandom_range(3, 0));
      mode_left = $urandom_range(64, 16);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      cipher_stall <= 1'b1;
    end else begin
      case (stall_mode)
        FlowFree:  cipher_stall <= 1'b0;
        FlowLight: cipher_stall <= ($urandom_range(3, 0) == 0);
        FlowHeavy: cipher_stall <= ($urandom_range(3, 0) != 0);
        default:   cipher_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && cipher_valid && !cipher_stall)
      board.check_letter(cipher_letter, last_of_run);
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (cipher_valid && !cipher_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: %0d cycles without a beat", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] ch, input logic eom);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(20, 1);
    end
    text_valid <= 1'b1;
    text_byte <= ch;
    end_of_message <= eom;
    do @(posedge clk); while (text_stall);
    board.note_text(ch, eom);
    beats_sent++;
    if (eom || (ch >= AsciiUpperA && ch <= AsciiUpperZ) ||
        (ch >= AsciiLowerA && ch <= AsciiLowerZ))
      useful_beats++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eom_last);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], eom_last && (i == s.len() - 1));
  endtask

  task automatic send_message();
    int          len;
    int          code;
    int          prev;
    bit          tail_noise;
    logic [7:0]  ch;
    len = $urandom_range(9, 1);
    tail_noise = ($urandom_range(3, 0) == 0);
    prev = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7, 0) == 0)
        send_beat(8'($urandom_range(255, 0)), 1'b0);
      code = (i > 0 && $urandom_range(4, 0) == 0) ? prev : $urandom_range(25, 0);
      prev = code;
      ch = $urandom_range(1, 0) ? AsciiUpperA + 8'(code) : AsciiLowerA + 8'(code);
      send_beat(ch, !tail_noise && (i == len - 1));
    end
    if (tail_noise)
      send_beat(8'($urandom_range(255, 0)), 1'b1);
  endtask

  task automatic run_random(input int target);
    int start;
    start = useful_beats;
    while (useful_beats - start < target) begin
      if ($urandom_range(9, 0) < 8)
        send_message();
      else
        send_beat(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
    end
  endtask

  task automatic finish_phase();
    text_valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_square(input square_t sq);
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      case (i)
        0:       cfg_index <= CfgRow0;
        1:       cfg_index <= CfgRow1;
        2:       cfg_index <= CfgRow2;
        3:       cfg_index <= CfgRow3;
        default: cfg_index <= CfgRow4;
      endcase
      cfg_data <= sq[i];
      board.set_row(i, sq[i]);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
    squares_loaded++;
  endtask

  function automatic square_t shuffled_square(code_t skip);
    code_t   pool [25];
    int      n;
    int      j;
    code_t   t;
    row_t    rw;
    square_t sq;
    n = 0;
    for (int c = 0; c < 26; c++) begin
      if (5'(c) != skip) begin
        pool[n] = 5'(c);
        n++;
      end
    end
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int r = 0; r < 5; r++) begin
      rw = '0;
      for (int c = 0; c < 5; c++) rw[5 * c +: 5] = pool[r * 5 + c];
      sq[r] = rw;
    end
    return sq;
  endfunction

  initial begin
    square_t raw;
    board = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CfgRow0;
    cfg_data = '0;
    text_valid = 1'b0;
    text_byte = '0;
    end_of_message = 1'b0;
    cipher_stall = 1'b0;
    stall_mode = FlowFree;
    mode_left = 0;
    hold_req = 0;
    hold_left = 0;
    holds_done = 0;
    burst_left = 0;
    beats_sent = 0;
    useful_beats = 0;
    squares_loaded = 1;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // standard square: pairs, doubled letters, j folding, non-letters, flushes
    send_text("HiEe", 1'b0);
    send_text("jIJ", 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_text("ZZZ", 1'b0);
    send_beat(8'h2E, 1'b1);
    send_text("XXA", 1'b0);
    send_text("AA", 1'b1);
    send_text("Q", 1'b1);
    send_beat(8'h40, 1'b0);
    send_beat(8'h5B, 1'b0);
    send_beat(8'h60, 1'b0);
    send_beat(8'h7B, 1'b1);
    send_text("az", 1'b1);
    finish_phase();

    // long receiver hold while the sender keeps offering
    hold_req = 1;
    run_random(25);
    finish_phase();

    load_square(shuffled_square(LetterJ));
    run_random(25);
    finish_phase();

    load_square('0);
    run_random(10);
    finish_phase();

    load_square('1);
    run_random(10);
    finish_phase();

    for (int r = 0; r < 5; r++) raw[r] = 25'($urandom);
    load_square(raw);
    run_random(12);
    finish_phase();

    load_square(shuffled_square(LetterI));
    run_random(10);
    finish_phase();

    if (board.pending() != 0) begin
      $display("%0d cipher letters never arrived", board.pending());
      board.errors += board.pending();
    end
    $display("covered %0d text beats (%0d letters or flushes) over %0d key squares",
             beats_sent, useful_beats, squares_loaded);
    $display("%0d cipher letters checked, %0d doubled-letter splits, %0d end flushes, %0d errors",
             board.letters_checked, board.splits, board.flushes, board.errors);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
